// ----- hdl/okvd_pkg.sv -----
// shared types and codes for the ordered key-value deque
// no dependencies; compiled first
`default_nettype none
package okvd_pkg;

  localparam int CMD_BITS    = 3;
  localparam int WORD_BITS   = 32;
  localparam int POS_BITS    = 6;
  localparam int STATUS_BITS = 3;
  localparam int LEN_BITS    = 5;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_INSERT_AT  = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP     = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_BAD_POS   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_SH_RD,
    S_SH_WR,
    S_PLACE,
    S_POP_RD,
    S_POP_WAIT,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/okvd_if.sv -----
// request and response channel interfaces of the deque
// depends on okvd_pkg for field widths
`default_nettype none
interface okvd_req_if import okvd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic        [CMD_BITS-1:0]  cmd;
  logic signed [WORD_BITS-1:0] key;
  logic signed [WORD_BITS-1:0] value;
  logic signed [POS_BITS-1:0]  position;
  modport source (output valid, cmd, key, value, position, input ready);
  modport sink   (input valid, cmd, key, value, position, output ready);
endinterface

interface okvd_rsp_if import okvd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [STATUS_BITS-1:0] status;
  logic signed [WORD_BITS-1:0]   out_key;
  logic signed [WORD_BITS-1:0]   out_value;
  logic        [LEN_BITS-1:0]    length;
  modport source (output valid, status, out_key, out_value, length, input ready);
  modport sink   (input valid, status, out_key, out_value, length, output ready);
endinterface
`default_nettype wire

// ----- hdl/okvd_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module okvd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ordered_key_value_deque.sv -----
// top level of the ordered key-value deque: sequencer around one entry ram
// depends on okvd_pkg, okvd_if and okvd_ram
`default_nettype none
// Bounded ordered table of unique keys, kept front to back in one ram that
// holds {key, value} per entry at its logical position. One request is
// worked at a time and gives exactly one response. Push, insert and lookup
// first scan the ram for the key, one read per cycle. A hit of a push or
// insert rewrites the value and a lookup hit returns it. On a miss that
// passes the checks, the entries from the insert point on shift up one
// slot, a read and a write state per moved entry, and the new entry is
// written. Pops read the end entry through a read and a wait state; a front
// pop then shifts the rest down, a read and a write state per entry. Every
// request passes the accept state and the finish state that loads the output
// register; the single ram read port forces the entry-by-entry scan and
// shifts. A new request is taken while a finished response still waits on
// the output.
module ordered_key_value_deque
  import okvd_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int DATA_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  okvd_req_if.sink   req,
  okvd_rsp_if.source rsp
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  // latched request
  logic [CMD_BITS-1:0]        cmd_r;
  logic [DATA_BITS-1:0]       key_r;
  logic [DATA_BITS-1:0]       val_r;
  logic signed [POS_BITS-1:0] pos_r;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // scan or shift pointer
  logic [CW-1:0] ridx;     // index of the read now in flight
  logic          rvalid;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] at_r;

  // result under construction
  logic [STATUS_BITS-1:0] res_status;
  logic [DATA_BITS-1:0]   res_key;
  logic [DATA_BITS-1:0]   res_val;

  // output register
  logic                   out_valid;
  logic [STATUS_BITS-1:0] out_status;
  logic [DATA_BITS-1:0]   out_k;
  logic [DATA_BITS-1:0]   out_v;
  logic [CW-1:0]          out_len;

  // ram port
  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [2*DATA_BITS-1:0] ram_wdata, ram_rdata;
  logic [DATA_BITS-1:0]   rd_key, rd_val;

  assign rd_key = ram_rdata[2*DATA_BITS-1:DATA_BITS];
  assign rd_val = ram_rdata[DATA_BITS-1:0];

  okvd_ram #(.WIDTH(2 * DATA_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic req_xfer, rsp_load;
  logic scan_match, scan_last, is_search, is_pop;
  logic bad_pos, is_full;
  logic [CW:0] idx_plus2;

  assign req_xfer   = req.valid && req.ready;
  assign rsp_load   = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign scan_match = rvalid && (rd_key == key_r);
  assign scan_last  = rvalid && (ridx == count - 1'b1);
  assign is_search  = (req.cmd == CMD_PUSH_BACK) || (req.cmd == CMD_PUSH_FRONT) ||
                      (req.cmd == CMD_INSERT_AT) || (req.cmd == CMD_LOOKUP);
  assign is_pop     = (req.cmd == CMD_POP_BACK) || (req.cmd == CMD_POP_FRONT);
  assign bad_pos    = (cmd_r == CMD_INSERT_AT) &&
                      ((pos_r < 0) || (int'(pos_r) > int'(count)));
  assign is_full    = (int'(count) >= CAPACITY);
  assign idx_plus2  = {1'b0, idx} + (CW + 1)'(2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (is_search) begin
            state_next = S_SCAN;
          end else if (is_pop && count != '0) begin
            state_next = S_POP_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (count == '0 || (!scan_match && scan_last)) begin
          state_next = S_MISS;
        end else if (scan_match) begin
          state_next = S_HIT;
        end
      end
      S_HIT: state_next = S_FINISH;
      S_MISS: begin
        if (cmd_r == CMD_LOOKUP || bad_pos || is_full) begin
          state_next = S_FINISH;
        end else if (cmd_r == CMD_PUSH_BACK) begin
          state_next = S_PLACE;
        end else if (count != '0 && (cmd_r == CMD_PUSH_FRONT ||
                     IW'($unsigned(pos_r)) < IW'(count))) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: begin
        if ((idx - 1'b1) > CW'(at_r)) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE:  state_next = S_FINISH;
      S_POP_RD: state_next = S_POP_WAIT;
      S_POP_WAIT: begin
        if (cmd_r == CMD_POP_FRONT && count > CW'(1)) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DN_RD: state_next = S_DN_WR;
      S_DN_WR: begin
        if (idx_plus2 < {1'b0, count}) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control and handshake
  always_comb begin
    req.ready = (state == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {key_r, val_r};
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_SCAN: begin
        // one read a cycle while entries remain and no match is seen
        ram_re    = (idx < count) && !scan_match;
        ram_raddr = idx[IW-1:0];
      end
      S_HIT: begin
        ram_we    = (cmd_r != CMD_LOOKUP);
        ram_waddr = hit_idx;
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(idx - 1'b1);
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = at_r;
      end
      S_POP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (cmd_r == CMD_POP_BACK) ? IW'(count - 1'b1) : '0;
      end
      S_DN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(idx + 1'b1);
      end
      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IW-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a load wins over the drain of the previous response
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            cmd_r      <= req.cmd;
            key_r      <= DATA_BITS'($unsigned(req.key));
            val_r      <= DATA_BITS'($unsigned(req.value));
            pos_r      <= req.position;
            idx        <= '0;
            rvalid     <= 1'b0;
            res_key    <= '0;
            res_val    <= '0;
            res_status <= (is_pop && count == '0) ? ST_EMPTY : ST_ADDED;
          end
        end
        S_SCAN: begin
          if (scan_match) begin
            hit_idx <= ridx[IW-1:0];
            rvalid  <= 1'b0;
          end else begin
            rvalid <= (idx < count);
            ridx   <= idx;
            idx    <= idx + 1'b1;
          end
        end
        S_HIT: begin
          if (cmd_r == CMD_LOOKUP) begin
            res_key <= key_r;
            res_val <= rd_val;
          end else begin
            res_status <= ST_UPDATED;
          end
        end
        S_MISS: begin
          idx <= count;
          if (cmd_r == CMD_LOOKUP) begin
            res_status <= ST_NOT_FOUND;
          end else if (bad_pos) begin
            res_status <= ST_BAD_POS;
          end else if (is_full) begin
            res_status <= ST_FULL;
          end else if (cmd_r == CMD_PUSH_BACK) begin
            at_r <= IW'(count);
          end else if (cmd_r == CMD_PUSH_FRONT) begin
            at_r <= '0;
          end else begin
            at_r <= IW'($unsigned(pos_r));
          end
        end
        S_SH_WR: idx <= idx - 1'b1;
        S_PLACE: count <= count + 1'b1;
        S_POP_WAIT: begin
          res_key <= rd_key;
          res_val <= rd_val;
          idx     <= '0;
          if (!(cmd_r == CMD_POP_FRONT && count > CW'(1))) begin
            count <= count - 1'b1;
          end
        end
        S_DN_WR: begin
          idx <= idx + 1'b1;
          if (!(idx_plus2 < {1'b0, count})) begin
            count <= count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // response payload, loaded with the transfer into the output register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_status <= res_status;
      out_k      <= res_key;
      out_v      <= res_val;
      out_len    <= count;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.out_key   = WORD_BITS'(out_k);
  assign rsp.out_value = WORD_BITS'(out_v);
  assign rsp.length    = LEN_BITS'(out_len);

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("entry count above capacity");

  // count never jumps by more than one at a clock edge
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count == $past(count) - 1'b1))
    else $error("entry count jumped");

  // one request at a time: no second transfer right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req.ready)
    else $error("request taken while busy");

endmodule
`default_nettype wire

// ----- dv/tb_ordered_key_value_deque.sv -----
// self-checking testbench for the ordered key-value deque
// depends on okvd_pkg, okvd_if and the deque rtl; runs standalone
`default_nettype none
module tb_ordered_key_value_deque;
  import okvd_pkg::*;

  localparam int DEPTH = 16;
  localparam int ITEM_COUNT = 1100;

  // command codes with no operation behind them
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CMD_BITS-1:0]         cmd;
    logic signed [WORD_BITS-1:0] key;
    logic signed [WORD_BITS-1:0] value;
    logic signed [POS_BITS-1:0]  position;
  } request_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic signed [WORD_BITS-1:0] out_key;
    logic signed [WORD_BITS-1:0] out_value;
    logic [LEN_BITS-1:0]         length;
  } response_t;

  logic clk;
  logic rst;

  okvd_req_if req ();
  okvd_rsp_if rsp ();

  ordered_key_value_deque #(.CAPACITY(DEPTH), .DATA_BITS(WORD_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // shadow of the table contents, front at index 0
  logic [WORD_BITS-1:0] table_keys[$];
  logic [WORD_BITS-1:0] table_values[$];

  request_t  pending_requests[$];
  response_t expected_responses[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;      // percent of cycles the sender holds back
  int recv_stall_pct = 0;     // percent of cycles the receiver stalls
  bit hold_off_start = 0;     // asks for the long receiver hold-off
  bit hold_off = 0;           // receiver held off while set
  bit stimulus_done = 0;

  // small key pool so pushes hit existing keys often
  logic [WORD_BITS-1:0] key_pool[8];

  // work out the response for one request and update the shadow table
  function automatic response_t predict_table_op(request_t r);
    response_t res;
    int hit;
    int pos;
    hit = -1;
    res = '0;
    res.status = ST_ADDED;
    pos = int'(r.position);
    case (r.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
        foreach (table_keys[i]) if (hit < 0 && table_keys[i] == r.key) hit = i;
        if (hit >= 0) begin
          table_values[hit] = r.value;
          res.status = ST_UPDATED;
        end else if (r.cmd == CMD_INSERT_AT && (pos < 0 || pos > table_keys.size())) begin
          res.status = ST_BAD_POS;
        end else if (table_keys.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else if (r.cmd == CMD_PUSH_BACK) begin
          table_keys.insert(table_keys.size(), r.key);
          table_values.insert(table_values.size(), r.value);
        end else if (r.cmd == CMD_PUSH_FRONT) begin
          table_keys.insert(0, r.key);
          table_values.insert(0, r.value);
        end else begin
          table_keys.insert(pos, r.key);
          table_values.insert(pos, r.value);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (table_keys.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (r.cmd == CMD_POP_BACK) begin
          res.out_key = table_keys[$];
          res.out_value = table_values[$];
          table_keys.delete(table_keys.size() - 1);
          table_values.delete(table_values.size() - 1);
        end else begin
          res.out_key = table_keys[0];
          res.out_value = table_values[0];
          table_keys.delete(0);
          table_values.delete(0);
        end
      end
      CMD_LOOKUP: begin
        foreach (table_keys[i]) if (hit < 0 && table_keys[i] == r.key) hit = i;
        if (hit >= 0) begin
          res.out_key = table_keys[hit];
          res.out_value = table_values[hit];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.length = LEN_BITS'(table_keys.size());
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    return WORD_BITS'({$urandom, $urandom} >> $urandom_range(32, 0));
  endfunction

  function automatic request_t make_request(logic [CMD_BITS-1:0] c, int k, int v, int p);
    request_t r;
    r.cmd = c;
    r.key = k;
    r.value = v;
    r.position = p[POS_BITS-1:0];
    return r;
  endfunction

  // add one request at the tail of the pending queue
  function automatic void queue_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // random request biased toward the key pool and legal positions
  function automatic request_t random_request();
    logic [CMD_BITS-1:0] c;
    logic [WORD_BITS-1:0] k;
    int p;
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) c = CMD_PUSH_BACK;
    else if (sel < 45) c = CMD_PUSH_FRONT;
    else if (sel < 58) c = CMD_POP_BACK;
    else if (sel < 70) c = CMD_POP_FRONT;
    else if (sel < 85) c = CMD_INSERT_AT;
    else if (sel < 97) c = CMD_LOOKUP;
    else c = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : rand_word();
    if ($urandom_range(9) == 0) p = $urandom_range(31) - 32 + $urandom_range(63) % 32;
    else p = $urandom_range(17);
    return make_request(c, k, rand_word(), p);
  endfunction

  // clock and reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // driver: offers the next pending request, idling at random
  initial begin
    req.valid = 0;
    req.cmd = '0;
    req.key = '0;
    req.value = '0;
    req.position = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 0;
    end else if (!req.valid || req.ready) begin
      // previous transfer done or nothing offered
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_requests[0];
        pending_requests.delete(0);
        expected_responses.insert(expected_responses.size(), predict_table_op(r));
        req.valid <= 1;
        req.cmd <= r.cmd;
        req.key <= r.key;
        req.value <= r.value;
        req.position <= r.position;
      end else begin
        req.valid <= 0;
      end
    end
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin
    wait (hold_off_start);
    @(posedge clk);
    hold_off <= 1;
    repeat (300) @(posedge clk);
    hold_off <= 0;
  end

  // receiver ready, with random stalls and the long hold-off
  initial rsp.ready = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_off) begin
      rsp.ready <= 0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compares each response transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_responses.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected response: status %0d", rsp.status);
      end else begin
        response_t e;
        e = expected_responses[0];
        expected_responses.delete(0);
        if (e.status !== rsp.status || e.out_key !== rsp.out_key ||
            e.out_value !== rsp.out_value || e.length !== rsp.length) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: exp st %0d k %h v %h len %0d, got st %0d k %h v %h len %0d",
                     e.status, e.out_key, e.out_value, e.length,
                     rsp.status, rsp.out_key, rsp.out_value, rsp.length);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_responses.size() != 0 || req.valid)
      @(posedge clk);
  endtask

  // stimulus phases
  initial begin
    int p;
    foreach (key_pool[i]) key_pool[i] = rand_word();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    @(negedge rst);

    // directed: empty pops, misses, extremes, bad positions, fill to full
    queue_request(make_request(CMD_POP_BACK, 0, 0, 0));
    queue_request(make_request(CMD_POP_FRONT, 0, 0, 0));
    queue_request(make_request(CMD_LOOKUP, 32'h8000_0000, 0, 0));
    queue_request(make_request(CMD_INSERT_AT, 5, 9, 1));
    queue_request(make_request(CMD_INSERT_AT, 5, 9, -1));
    queue_request(make_request(CMD_INSERT_AT, 32'h8000_0000, 32'h7fff_ffff, 0));
    queue_request(make_request(CMD_PUSH_BACK, 32'h7fff_ffff, 32'h8000_0000, 0));
    queue_request(make_request(CMD_PUSH_FRONT, 32'hffff_ffff, 32'hffff_ffff, 0));
    queue_request(make_request(CMD_INSERT_AT, 3, 33, 3));   // append at length
    queue_request(make_request(CMD_INSERT_AT, 4, 44, 3));   // before last
    queue_request(make_request(CMD_PUSH_BACK, 3, 55, 0));   // key present
    queue_request(make_request(CMD_LOOKUP, 3, 0, 0));
    queue_request(make_request(CMD_INSERT_AT, 6, 1, 31));
    queue_request(make_request(CMD_INSERT_AT, 6, 1, -32));
    queue_request(make_request(CMD_SPARE_HI, 1, 1, 0));
    queue_request(make_request(CMD_SPARE_LO, 1, 1, 0));
    for (p = 0; p < 12; p++) queue_request(make_request(CMD_PUSH_BACK, 100 + p, p, 0));
    queue_request(make_request(CMD_PUSH_FRONT, 999, 1, 0));           // full
    queue_request(make_request(CMD_INSERT_AT, 4, 77, 40));            // update when full
    queue_request(make_request(CMD_POP_FRONT, 0, 0, 0));
    queue_request(make_request(CMD_POP_BACK, 0, 0, 0));
    wait_drained();

    // random phases: free running, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 20 : 0;
      recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 20 : 0;
      repeat (ITEM_COUNT / 4) queue_request(random_request());
      if (ph == 0) begin
        // long hold-off while requests keep coming, so the input backs up
        @(posedge clk);
        hold_off_start = 1;
      end
      wait_drained();
    end
    stimulus_done = 1;
  end

  // end of run
  initial begin
    @(posedge stimulus_done);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- ordered_key_value_deque.f -----
hdl/okvd_pkg.sv
hdl/okvd_if.sv
hdl/okvd_ram.sv
hdl/ordered_key_value_deque.sv
dv/tb_ordered_key_value_deque.sv
